/* hw/rtl/mim_pkg.sv */
// ----------------------------------------------------------------------------
// mim_pkg
// Shared types and constants of the minimum-image wrap datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package mim_pkg;

	// default data format of the displacement ports
	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;

	// matrix entry format: signed 32-bit halves of the packed registers
	localparam int COEF_W = 32;
	localparam int INV_F  = 28;
	localparam int CELL_F = 16;

	// fractional coordinate format, Q12.24
	localparam int S_F = 24;
	localparam int S_W = 36;

	// configuration port
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;

	// pipeline depth of one matrix-vector unit, and of the whole block
	localparam int MV_STAGES = 4;
	localparam int MIM_LAT   = 2 * MV_STAGES + 1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CELL_DIAG_AB  = 3'd0,
		REG_CELL_ZZ_XY    = 3'd1,
		REG_CELL_XZ_YZ    = 3'd2,
		REG_INV_DIAG_AB   = 3'd3,
		REG_INV_ZZ_XY     = 3'd4,
		REG_INV_XZ_YZ     = 3'd5,
		REG_PERIODIC_MASK = 3'd6
	} cfg_idx_t;

	// upper-triangular 3x3 matrix
	typedef struct packed {
		logic signed [COEF_W-1:0] m00;
		logic signed [COEF_W-1:0] m01;
		logic signed [COEF_W-1:0] m02;
		logic signed [COEF_W-1:0] m11;
		logic signed [COEF_W-1:0] m12;
		logic signed [COEF_W-1:0] m22;
	} tri_t;

	// control that travels down the pipeline with each word
	typedef struct packed {
		logic vld;
		logic sat;
	} ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/minimum_image_wrap.sv */
// ----------------------------------------------------------------------------
// minimum_image_wrap
// Minimum-image reduction of a displacement in a triclinic periodic cell:
// s = Hinv * d, nearest integer removed on periodic axes, r = H * s.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   handshake
//  input     start, busy, in_dx, in_dy, in_dz          start && !busy
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//  result    done, out_dx, out_dy, out_dz, saturated   done, one cycle
//
//  One word is taken every cycle; busy stays low and cfg_ready stays high.
//  A taken word passes through four stages for the inverse-cell product,
//  one for the wrap and four for the cell product before its result appears.
//  The stages of the two matrix units and the wrap register make up the pipe.
//  Reset clears the pipeline valid bits and loads H = I, Hinv = I, all axes
//  periodic. Results cannot be held off, so nothing in the pipe ever stalls.
//
`default_nettype none

module minimum_image_wrap
	import mim_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic signed [COORD_WIDTH-1:0] in_dx,
	input  logic signed [COORD_WIDTH-1:0] in_dy,
	input  logic signed [COORD_WIDTH-1:0] in_dz,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic        [CFG_IDX_W-1:0]   cfg_index,
	input  logic        [CFG_W-1:0]       cfg_data,
	output logic                          done,
	output logic signed [COORD_WIDTH-1:0] out_dx,
	output logic signed [COORD_WIDTH-1:0] out_dy,
	output logic signed [COORD_WIDTH-1:0] out_dz,
	output logic                          saturated
);

	localparam int SHIFT1 = FRAC_BITS + INV_F - S_F;
	localparam int SHIFT2 = CELL_F + S_F - FRAC_BITS;

	localparam logic [S_F-1:0] S_HALF = S_F'(1) << (S_F - 1);
	localparam logic [S_W-1:0] S_ONE  = S_W'(1) << S_F;

	logic [CFG_W-1:0] cell_diag_ab_q, cell_zz_xy_q, cell_xz_yz_q;
	logic [CFG_W-1:0] inv_diag_ab_q, inv_zz_xy_q, inv_xz_yz_q;
	logic [2:0]       periodic_mask_q;

	tri_t inv_m, cell_m;

	ctl_t                          ctl_in, ctl_a, ctl_s5, ctl_b;
	logic signed [COORD_WIDTH-1:0] d_vec [3];
	logic signed [S_W-1:0]         s_a   [3];
	logic signed [S_W-1:0]         s_s5  [3];
	logic signed [S_W-1:0]         s_wrp [3];
	logic signed [COORD_WIDTH-1:0] r_b   [3];
	logic        [S_F-1:0]         frac  [3];
	logic        [2:0]             rnd_up;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_diag_ab_q  <= 64'h0001_0000_0001_0000;
			cell_zz_xy_q    <= 64'h0000_0000_0001_0000;
			cell_xz_yz_q    <= '0;
			inv_diag_ab_q   <= 64'h1000_0000_1000_0000;
			inv_zz_xy_q     <= 64'h0000_0000_1000_0000;
			inv_xz_yz_q     <= '0;
			periodic_mask_q <= 3'b111;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_CELL_DIAG_AB:  cell_diag_ab_q  <= cfg_data;
				REG_CELL_ZZ_XY:    cell_zz_xy_q    <= cfg_data;
				REG_CELL_XZ_YZ:    cell_xz_yz_q    <= cfg_data;
				REG_INV_DIAG_AB:   inv_diag_ab_q   <= cfg_data;
				REG_INV_ZZ_XY:     inv_zz_xy_q     <= cfg_data;
				REG_INV_XZ_YZ:     inv_xz_yz_q     <= cfg_data;
				REG_PERIODIC_MASK: periodic_mask_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_comb begin
		inv_m.m00  = inv_diag_ab_q[31:0];
		inv_m.m11  = inv_diag_ab_q[63:32];
		inv_m.m22  = inv_zz_xy_q[31:0];
		inv_m.m01  = inv_zz_xy_q[63:32];
		inv_m.m02  = inv_xz_yz_q[31:0];
		inv_m.m12  = inv_xz_yz_q[63:32];
		cell_m.m00 = cell_diag_ab_q[31:0];
		cell_m.m11 = cell_diag_ab_q[63:32];
		cell_m.m22 = cell_zz_xy_q[31:0];
		cell_m.m01 = cell_zz_xy_q[63:32];
		cell_m.m02 = cell_xz_yz_q[31:0];
		cell_m.m12 = cell_xz_yz_q[63:32];
	end

	assign ctl_in.vld = start && !busy;
	assign ctl_in.sat = 1'b0;
	assign d_vec[0]   = in_dx;
	assign d_vec[1]   = in_dy;
	assign d_vec[2]   = in_dz;

	// fractional coordinates, Q12.24
	mim_matvec #(
		.IN_W  (COORD_WIDTH),
		.OUT_W (S_W),
		.SHIFT (SHIFT1)
	) u_frac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_in),
		.coef    (inv_m),
		.vec     (d_vec),
		.ctl_out (ctl_a),
		.res     (s_a)
	);

	// drop the nearest integer, halves away from zero
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			frac[i]   = s_a[i][S_F-1:0];
			rnd_up[i] = (frac[i] > S_HALF) || ((frac[i] == S_HALF) && !s_a[i][S_W-1]);
			s_wrp[i]  = S_W'(frac[i]) - (rnd_up[i] ? S_ONE : '0);
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			s_s5[i] <= periodic_mask_q[i] ? s_wrp[i] : s_a[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
		end else begin
			ctl_s5 <= ctl_a;
		end
	end

	// back to cartesian, Q16.16 cell
	mim_matvec #(
		.IN_W  (S_W),
		.OUT_W (COORD_WIDTH),
		.SHIFT (SHIFT2)
	) u_cart (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s5),
		.coef    (cell_m),
		.vec     (s_s5),
		.ctl_out (ctl_b),
		.res     (r_b)
	);

	assign done      = ctl_b.vld;
	assign saturated = ctl_b.sat;
	assign out_dx    = r_b[0];
	assign out_dy    = r_b[1];
	assign out_dz    = r_b[2];

endmodule

`default_nettype wire

/* hw/rtl/mim_matvec.sv */
// ----------------------------------------------------------------------------
// mim_matvec
// Four-stage upper-triangular matrix times vector, exact sums, rounded
// (halves up) by SHIFT bits and saturated to OUT_W bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mim_matvec
	import mim_pkg::*;
#(
	parameter int IN_W  = 32,
	parameter int OUT_W = 36,
	parameter int SHIFT = 20
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ctl_t                    ctl_in,
	input  tri_t                    coef,
	input  logic signed [IN_W-1:0]  vec [3],
	output ctl_t                    ctl_out,
	output logic signed [OUT_W-1:0] res [3]
);

	localparam int LO_W   = IN_W / 2;
	localparam int HI_W   = IN_W - LO_W;
	localparam int PH_W   = COEF_W + HI_W;
	localparam int PL_W   = COEF_W + LO_W + 1;
	localparam int PROD_W = COEF_W + IN_W;
	localparam int ACC_W  = PROD_W + 2;
	localparam int CMP_W  = (ACC_W > OUT_W) ? ACC_W : OUT_W + 1;
	localparam int NTERM  = 6;

	// vector element that each nonzero entry multiplies: 00 01 02 11 12 22
	localparam int TERM_COL [NTERM] = '{0, 1, 2, 1, 2, 2};

	localparam logic signed [ACC_W-1:0] RND  = ACC_W'(1) << (SHIFT - 1);
	localparam logic signed [CMP_W-1:0] MAXV = (CMP_W'(1) << (OUT_W - 1)) - CMP_W'(1);
	localparam logic signed [CMP_W-1:0] MINV = -(CMP_W'(1) << (OUT_W - 1));

	logic signed [COEF_W-1:0] cf      [NTERM];
	logic signed [PH_W-1:0]   ph_s1   [NTERM];
	logic signed [PL_W-1:0]   pl_s1   [NTERM];
	logic signed [PROD_W-1:0] prod_s2 [NTERM];
	logic signed [ACC_W-1:0]  acc_s3  [3];
	logic signed [CMP_W-1:0]  wide    [3];
	logic        [2:0]        over;
	logic        [2:0]        under;
	logic signed [OUT_W-1:0]  res_s4  [3];
	ctl_t                     ctl_s1, ctl_s2, ctl_s3, ctl_s4;

	always_comb begin
		cf[0] = coef.m00;
		cf[1] = coef.m01;
		cf[2] = coef.m02;
		cf[3] = coef.m11;
		cf[4] = coef.m12;
		cf[5] = coef.m22;
	end

	// stage 1: each product split into a signed high half and an unsigned low half
	always_ff @(posedge clk) begin
		for (int k = 0; k < NTERM; k++) begin
			ph_s1[k] <= PH_W'(cf[k]) * PH_W'($signed(vec[TERM_COL[k]][IN_W-1:LO_W]));
			pl_s1[k] <= PL_W'(cf[k]) * PL_W'($signed({1'b0, vec[TERM_COL[k]][LO_W-1:0]}));
		end
	end

	// stage 2: recombine the halves
	always_ff @(posedge clk) begin
		for (int k = 0; k < NTERM; k++) begin
			prod_s2[k] <= (PROD_W'(ph_s1[k]) <<< LO_W) + PROD_W'(pl_s1[k]);
		end
	end

	// stage 3: row sums, rounding constant folded in
	always_ff @(posedge clk) begin
		acc_s3[0] <= ACC_W'(prod_s2[0]) + ACC_W'(prod_s2[1]) + ACC_W'(prod_s2[2]) + RND;
		acc_s3[1] <= ACC_W'(prod_s2[3]) + ACC_W'(prod_s2[4]) + RND;
		acc_s3[2] <= ACC_W'(prod_s2[5]) + RND;
	end

	// stage 4: shift and clip
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			wide[r]  = CMP_W'(acc_s3[r]) >>> SHIFT;
			over[r]  = wide[r] > MAXV;
			under[r] = wide[r] < MINV;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			if (over[r]) begin
				res_s4[r] <= MAXV[OUT_W-1:0];
			end else if (under[r]) begin
				res_s4[r] <= MINV[OUT_W-1:0];
			end else begin
				res_s4[r] <= wide[r][OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1     <= ctl_in;
			ctl_s2     <= ctl_s1;
			ctl_s3     <= ctl_s2;
			ctl_s4.vld <= ctl_s3.vld;
			ctl_s4.sat <= ctl_s3.sat | (|over) | (|under);
		end
	end

	assign ctl_out = ctl_s4;
	assign res     = res_s4;

endmodule

`default_nettype wire

/* hw/rtl/mim_checker.sv */
// ----------------------------------------------------------------------------
// mim_checker
// Port-level checks of the minimum-image wrap: fixed latency, no lost or
// invented results, configuration always taken.
// ----------------------------------------------------------------------------
`default_nettype none

module mim_checker
	import mim_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic cfg_valid,
	input logic cfg_ready
);

	// every accepted word comes out after the pipeline latency
	a_accept_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##MIM_LAT done)
		else $error("accepted word produced no result");

	// no result without a word accepted one latency earlier
	a_done_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, MIM_LAT))
		else $error("result without an accepted word");

	// the pipeline never pushes back on the input
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("input word refused");

	// register writes are always taken
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config word refused");

endmodule

bind minimum_image_wrap mim_checker u_mim_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

/* sim/minimum_image_wrap_tb.sv */
// ----------------------------------------------------------------------------
// minimum_image_wrap_tb
// Self-checking bench for the minimum-image wrap block. Displacement words
// stream in through start/busy. The cell and inverse-cell registers are
// reloaded between phases while the pipe is empty: identity, realistic
// triclinic cells, extreme bit patterns and pure noise. Each result is
// checked against an in-bench fixed-point model of the two matrix products,
// the wrap and the saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_image_wrap_tb;
	import mim_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW         = COORD_WIDTH_DEF;
	localparam int SHIFT_FRAC = FRAC_BITS_DEF + INV_F - S_F;
	localparam int SHIFT_BACK = CELL_F + S_F - FRAC_BITS_DEF;
	localparam int RUN_LIMIT  = 200000;

	// index past the register file, writes to it are dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
	} disp_t;

	typedef struct packed {
		logic signed [CW-1:0] dx;
		logic signed [CW-1:0] dy;
		logic signed [CW-1:0] dz;
		logic                 sat;
	} wrapped_t;

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 start     = 1'b0;
	logic                 busy;
	logic signed [CW-1:0] in_dx     = '0;
	logic signed [CW-1:0] in_dy     = '0;
	logic signed [CW-1:0] in_dz     = '0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 done;
	logic signed [CW-1:0] out_dx;
	logic signed [CW-1:0] out_dy;
	logic signed [CW-1:0] out_dz;
	logic                 saturated;

	// shadow of the register file, reset values: H = I, Hinv = I, all periodic
	logic [CFG_W-1:0] cell_regs [7] = '{
		64'h0001_0000_0001_0000, 64'h0000_0000_0001_0000, 64'h0,
		64'h1000_0000_1000_0000, 64'h0000_0000_1000_0000, 64'h0, 64'h7
	};

	disp_t       pending_disp [$];
	wrapped_t    expected_wrap [$];
	bit          gaps_on = 1'b1;
	int          reach   = 4 << FRAC_BITS_DEF;
	int          errors  = 0;
	int unsigned cycles  = 0;

	minimum_image_wrap DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.in_dx     (in_dx),
		.in_dy     (in_dy),
		.in_dz     (in_dz),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.done      (done),
		.out_dx    (out_dx),
		.out_dy    (out_dy),
		.out_dz    (out_dz),
		.saturated (saturated)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic logic signed [127:0] round_shift(logic signed [127:0] v, int n);
		return (v + (128'sd1 <<< (n - 1))) >>> n;
	endfunction

	function automatic logic signed [127:0] clip_to(logic signed [127:0] v, int w);
		logic signed [127:0] maxv;
		logic signed [127:0] minv;
		maxv = (128'sd1 <<< (w - 1)) - 128'sd1;
		minv = -(128'sd1 <<< (w - 1));
		if (v > maxv) return maxv;
		if (v < minv) return minv;
		return v;
	endfunction

	// s = Hinv * d, drop nearest integer on periodic axes, r = H * s
	function automatic wrapped_t wrap_displacement(disp_t d);
		logic signed [127:0] inv_m [3][3];
		logic signed [127:0] cell_m [3][3];
		logic signed [127:0] vec [3];
		logic signed [127:0] frac [3];
		logic signed [127:0] back [3];
		logic signed [127:0] acc;
		logic signed [127:0] rnd;
		logic signed [127:0] whole;
		wrapped_t            res;
		res.sat = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++) begin
				inv_m[i][j]  = '0;
				cell_m[i][j] = '0;
			end
		cell_m[0][0] = 128'($signed(cell_regs[REG_CELL_DIAG_AB][31:0]));
		cell_m[1][1] = 128'($signed(cell_regs[REG_CELL_DIAG_AB][63:32]));
		cell_m[2][2] = 128'($signed(cell_regs[REG_CELL_ZZ_XY][31:0]));
		cell_m[0][1] = 128'($signed(cell_regs[REG_CELL_ZZ_XY][63:32]));
		cell_m[0][2] = 128'($signed(cell_regs[REG_CELL_XZ_YZ][31:0]));
		cell_m[1][2] = 128'($signed(cell_regs[REG_CELL_XZ_YZ][63:32]));
		inv_m[0][0]  = 128'($signed(cell_regs[REG_INV_DIAG_AB][31:0]));
		inv_m[1][1]  = 128'($signed(cell_regs[REG_INV_DIAG_AB][63:32]));
		inv_m[2][2]  = 128'($signed(cell_regs[REG_INV_ZZ_XY][31:0]));
		inv_m[0][1]  = 128'($signed(cell_regs[REG_INV_ZZ_XY][63:32]));
		inv_m[0][2]  = 128'($signed(cell_regs[REG_INV_XZ_YZ][31:0]));
		inv_m[1][2]  = 128'($signed(cell_regs[REG_INV_XZ_YZ][63:32]));
		vec[0] = 128'(d.dx);
		vec[1] = 128'(d.dy);
		vec[2] = 128'(d.dz);
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++)
				acc = acc + inv_m[i][j] * vec[j];
			rnd     = round_shift(acc, SHIFT_FRAC);
			frac[i] = clip_to(rnd, S_W);
			if (frac[i] != rnd)
				res.sat = 1'b1;
			if (cell_regs[REG_PERIODIC_MASK][i]) begin
				// nearest integer, halves away from zero
				if (frac[i] >= 0)
					whole = (frac[i] + (128'sd1 <<< (S_F - 1))) >>> S_F;
				else
					whole = -((-frac[i] + (128'sd1 <<< (S_F - 1))) >>> S_F);
				frac[i] = frac[i] - (whole <<< S_F);
			end
		end
		for (int i = 0; i < 3; i++) begin
			acc = '0;
			for (int j = 0; j < 3; j++)
				acc = acc + cell_m[i][j] * frac[j];
			rnd     = round_shift(acc, SHIFT_BACK);
			back[i] = clip_to(rnd, CW);
			if (back[i] != rnd)
				res.sat = 1'b1;
		end
		res.dx = back[0][CW-1:0];
		res.dy = back[1][CW-1:0];
		res.dz = back[2][CW-1:0];
		return res;
	endfunction

	task automatic flag_error(string what, logic [CW-1:0] got, logic [CW-1:0] want);
		$display("wrap check failed at cycle %0d: %s got %h expected %h", cycles, what, got,
			want);
		errors++;
	endtask

	// register shadow follows the config handshake
	always @(posedge clk) begin
		if (arst_n && cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_PERIODIC_MASK: cell_regs[REG_PERIODIC_MASK] <= {61'd0, cfg_data[2:0]};
				REG_UNUSED: ;
				default: cell_regs[cfg_index] <= cfg_data;
			endcase
		end
	end

	// driver: one displacement word per accepted start, random gaps
	always @(posedge clk) begin
		disp_t nxt;
		if (arst_n) begin
			if (start && !busy)
				expected_wrap.push_back(wrap_displacement({in_dx, in_dy, in_dz}));
			if (!start || !busy) begin
				if (pending_disp.size() != 0 && !(gaps_on && $urandom_range(99) < 7)) begin
					nxt = pending_disp.pop_front();
					start <= 1'b1;
					in_dx <= nxt.dx;
					in_dy <= nxt.dy;
					in_dz <= nxt.dz;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// monitor: results come on done and cannot be held off
	always @(posedge clk) begin
		wrapped_t want;
		if (arst_n && done) begin
			if (expected_wrap.size() == 0) begin
				flag_error("unexpected word, out_dx", out_dx, '0);
			end else begin
				want = expected_wrap.pop_front();
				if (out_dx !== want.dx)
					flag_error("out_dx", out_dx, want.dx);
				if (out_dy !== want.dy)
					flag_error("out_dy", out_dy, want.dy);
				if (out_dz !== want.dz)
					flag_error("out_dz", out_dz, want.dz);
				if (saturated !== want.sat)
					flag_error("saturated", CW'(saturated), CW'(want.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= RUN_LIMIT) begin
			$display("minimum_image_wrap: mismatch");
			$finish;
		end
	end

	function automatic logic [CW-1:0] fixq(real x, int f);
		return CW'($rtoi(x * (2.0 ** f)));
	endfunction

	function automatic logic [CW-1:0] pick_coord();
		int r;
		case ($urandom_range(9))
			0: return $urandom();
			1: begin
				case ($urandom_range(3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			2, 3: r = 1 << 18;
			default: r = reach;
		endcase
		return CW'(int'($urandom_range(2 * r)) - r);
	endfunction

	task automatic queue_disp(logic [CW-1:0] x, logic [CW-1:0] y, logic [CW-1:0] z);
		pending_disp.push_back({x, y, z});
	endtask

	// caller sits right after a rising edge; valid is left high for the next write
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	// close the write burst, queue n random words and wait for the pipe to empty
	task automatic run_phase(int n);
		cfg_valid <= 1'b0;
		repeat (n)
			pending_disp.push_back({pick_coord(), pick_coord(), pick_coord()});
		@(posedge clk);
		// look at the settled state between edges
		@(negedge clk);
		while (pending_disp.size() != 0 || start || expected_wrap.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic load_random_cell(logic [2:0] mask);
		real xx, yy, zz, xy, xz, yz, big;
		xx = 2.0 + $urandom_range(4000) / 100.0;
		yy = 2.0 + $urandom_range(4000) / 100.0;
		zz = 2.0 + $urandom_range(4000) / 100.0;
		xy = ($urandom_range(1000) / 1000.0 - 0.5) * xx;
		xz = ($urandom_range(1000) / 1000.0 - 0.5) * xx;
		yz = ($urandom_range(1000) / 1000.0 - 0.5) * yy;
		big = xx > yy ? (xx > zz ? xx : zz) : (yy > zz ? yy : zz);
		reach = $rtoi(3.0 * big * 65536.0);
		write_reg(REG_CELL_DIAG_AB, {fixq(yy, CELL_F), fixq(xx, CELL_F)});
		write_reg(REG_CELL_ZZ_XY, {fixq(xy, CELL_F), fixq(zz, CELL_F)});
		write_reg(REG_CELL_XZ_YZ, {fixq(yz, CELL_F), fixq(xz, CELL_F)});
		write_reg(REG_INV_DIAG_AB, {fixq(1.0 / yy, INV_F), fixq(1.0 / xx, INV_F)});
		write_reg(REG_INV_ZZ_XY, {fixq(-xy / (xx * yy), INV_F), fixq(1.0 / zz, INV_F)});
		write_reg(REG_INV_XZ_YZ, {fixq(-yz / (yy * zz), INV_F),
			fixq((xy * yz - xz * yy) / (xx * yy * zz), INV_F)});
		write_reg(REG_PERIODIC_MASK, {32'($urandom()), 29'($urandom()), mask});
	endtask

	initial begin
		logic [CFG_W-1:0] patterns [4] = '{
			64'h0, 64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_7FFF_FFFF, 64'h8000_0000_8000_0000
		};
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset cell: identity, all axes periodic
		queue_disp(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
		queue_disp(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
		queue_disp(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001);
		queue_disp(32'h0000_8000, 32'hFFFF_8000, 32'h0001_8000);
		queue_disp(32'h0000_7FFF, 32'hFFFF_8001, 32'h0000_8001);
		queue_disp(32'hFFFE_8000, 32'h0001_0000, 32'hFFFF_0000);
		// fractional coordinate right at and just past the Q12.24 edges
		queue_disp(32'h07FF_FFFF, 32'h0800_0000, 32'hF800_0000);
		queue_disp(32'hF7FF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF);
		queue_disp(32'h1234_5678, 32'hEDCB_A987, 32'h0000_FFFF);
		run_phase(0);

		// no wrapping, then a huge xx so the back product overflows
		write_reg(REG_PERIODIC_MASK, {32'($urandom()), 29'($urandom()), 3'b000});
		run_phase(0);
		queue_disp(32'h0001_8000, 32'hFFFE_8000, 32'h07FF_FFFF);
		queue_disp(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
		run_phase(0);
		write_reg(REG_CELL_DIAG_AB, {32'h0001_0000, 32'h7FFF_FFFF});
		run_phase(0);
		queue_disp(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		queue_disp(32'h0002_0000, 32'h0000_0000, 32'h0000_0000);
		queue_disp(32'hFFFE_0000, 32'h0000_0000, 32'h0000_0000);
		queue_disp(32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000);
		run_phase(0);

		// back-to-back stretch with no gaps
		gaps_on = 1'b0;
		load_random_cell(3'b111);
		run_phase(200);
		gaps_on = 1'b1;

		for (int k = 0; k < 6; k++) begin
			load_random_cell(k == 0 ? 3'b000 : k == 1 ? 3'b111 : 3'($urandom_range(7)));
			run_phase(90);
		end

		foreach (patterns[p]) begin
			for (int k = REG_CELL_DIAG_AB; k <= REG_PERIODIC_MASK; k++)
				write_reg(CFG_IDX_W'(k), patterns[p]);
			reach = 1 << 24;
			run_phase(30);
		end

		repeat (2) begin
			for (int k = REG_CELL_DIAG_AB; k <= REG_PERIODIC_MASK; k++)
				write_reg(CFG_IDX_W'(k), {32'($urandom()), 32'($urandom())});
			run_phase(60);
		end

		// a write past the register file must leave the cell alone
		load_random_cell(3'b111);
		write_reg(REG_UNUSED, {32'($urandom()), 32'($urandom())});
		run_phase(40);

		repeat (2 * MIM_LAT) @(posedge clk);
		if (errors == 0)
			$display("minimum_image_wrap: match");
		else
			$display("minimum_image_wrap: mismatch");
		$finish;
	end

endmodule

`default_nettype wire

/* sim.f */
hw/rtl/mim_pkg.sv
hw/rtl/mim_matvec.sv
hw/rtl/minimum_image_wrap.sv
hw/rtl/mim_checker.sv
sim/minimum_image_wrap_tb.sv
